// ----- rtl/core/qfg_pkg.sv -----
package qfg_pkg;

    // Fixed field and datapath widths.
    localparam int DATA_W = 32;
    localparam int IDX_W  = 4;
    localparam int DIM_W  = 5;
    localparam int OUT_W  = 64;
    localparam int PROD_W = 2 * (DATA_W + 1);
    localparam int GACC_W = PROD_W + 4;
    localparam int FACC_W = PROD_W + DATA_W + 2;

    // Gradient terms carry 16 fraction bits too many; f also folds in the factor one half.
    localparam int GRAD_SHIFT = 16;
    localparam int FUNC_SHIFT = 17;

    // Input operation codes.
    localparam logic OP_MATRIX = 1'b0;
    localparam logic OP_VECTOR = 1'b1;

    // Result kind codes.
    localparam logic RK_GRAD = 1'b0;
    localparam logic RK_FUNC = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_GAP,
        ST_FLO,
        ST_FHI,
        ST_DRAIN
    } t_state;

    // Kind of work issued to the shared multiplier.
    typedef enum logic [1:0] {
        K_MAC,
        K_FLO,
        K_FHI
    } t_kind;

    // Tag that travels down the pipeline next to each issued operation.
    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic             first;
        logic             last;
        logic             fin;
        logic [IDX_W-1:0] row;
    } t_tag;

    // Saturate a wide signed value to the signed 64-bit range.
    function automatic logic signed [OUT_W-1:0] sat64(input logic signed [FACC_W-1:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[FACC_W-1:OUT_W-1];
        all_zero = ~|v[FACC_W-1:OUT_W-1];
        if (all_one || all_zero) begin
            sat64 = v[OUT_W-1:0];
        end else if (v[FACC_W-1]) begin
            sat64 = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            sat64 = {1'b0, {(OUT_W-1){1'b1}}};
        end
    endfunction

endpackage

// ----- rtl/core/qfg_store.sv -----
module qfg_store
    import qfg_pkg::*;
#(
    parameter int MAX_DIMENSION = 16
) (
    input  logic              i_clk,
    input  logic              i_wr_p,
    input  logic              i_wr_x,
    input  logic [IDX_W-1:0]  i_wr_row,
    input  logic [IDX_W-1:0]  i_wr_col,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [IDX_W-1:0]  i_rd_row,
    input  logic [IDX_W-1:0]  i_rd_col,
    input  logic [IDX_W-1:0]  i_rd_xidx,
    output logic [DATA_W-1:0] o_p_q,
    output logic [DATA_W-1:0] o_x_q
);

    localparam int P_DEPTH = MAX_DIMENSION * MAX_DIMENSION;
    localparam int AW      = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int VW      = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
    localparam int LW      = AW + 5;

    logic [DATA_W-1:0] r_pmem [P_DEPTH];
    logic [DATA_W-1:0] r_xmem [MAX_DIMENSION];
    logic [DATA_W-1:0] r_p_q;
    logic [DATA_W-1:0] r_x_q;

    logic [LW-1:0] wr_row_w;
    logic [LW-1:0] wr_col_w;
    logic [LW-1:0] wr_addr_w;
    logic [LW-1:0] rd_addr_w;
    logic [LW-1:0] rd_xidx_w;
    logic          wr_row_ok;
    logic          wr_col_ok;

    // Row-major addressing; writes outside the stored dimension are dropped.
    always_comb begin
        wr_row_w  = LW'(i_wr_row);
        wr_col_w  = LW'(i_wr_col);
        wr_row_ok = wr_row_w < LW'(MAX_DIMENSION);
        wr_col_ok = wr_col_w < LW'(MAX_DIMENSION);
        wr_addr_w = wr_row_w * LW'(MAX_DIMENSION) + wr_col_w;
        rd_addr_w = LW'(i_rd_row) * LW'(MAX_DIMENSION) + LW'(i_rd_col);
        rd_xidx_w = LW'(i_rd_xidx);
    end

    // Precision matrix memory with registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_p && wr_row_ok && wr_col_ok) begin
            r_pmem[wr_addr_w[AW-1:0]] <= i_wr_data;
        end
        r_p_q <= r_pmem[rd_addr_w[AW-1:0]];
    end

    // Vector memory with registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_x && wr_row_ok) begin
            r_xmem[wr_row_w[VW-1:0]] <= i_wr_data;
        end
        r_x_q <= r_xmem[rd_xidx_w[VW-1:0]];
    end

    assign o_p_q = r_p_q;
    assign o_x_q = r_x_q;

endmodule

// ----- rtl/core/qfg_mac.sv -----
module qfg_mac
    import qfg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_go,
    input  t_tag                     i_tag,
    input  logic signed [DATA_W-1:0] i_p_q,
    input  logic signed [DATA_W-1:0] i_x_q,
    output logic                     o_done,
    output logic                     o_strobe,
    output logic                     o_result_kind,
    output logic [IDX_W-1:0]         o_result_index,
    output logic signed [OUT_W-1:0]  o_result_value,
    output logic                     o_run_end
);

    t_tag                     r_tag1;
    t_tag                     r_tag2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [GACC_W-1:0] r_gacc;
    logic signed [FACC_W-1:0] r_facc;
    logic signed [OUT_W-1:0]  r_g;
    logic                     r_fpend;
    logic                     r_strobe;
    logic                     r_kind;
    logic [IDX_W-1:0]         r_index;
    logic signed [OUT_W-1:0]  r_value;
    logic                     r_end;

    logic signed [DATA_W:0]   op_a;
    logic signed [DATA_W:0]   op_b;
    logic signed [GACC_W-1:0] g_sum;
    logic signed [OUT_W-1:0]  g_val;
    logic signed [FACC_W-1:0] f_add;
    logic signed [OUT_W-1:0]  f_val;

    // Operand select for the shared multiplier: P*x, or x times the low or the high half of g.
    always_comb begin
        case (r_tag1.kind)
            K_MAC: begin
                op_a = {i_p_q[DATA_W-1], i_p_q};
                op_b = {i_x_q[DATA_W-1], i_x_q};
            end
            K_FLO: begin
                op_a = {i_x_q[DATA_W-1], i_x_q};
                op_b = {1'b0, r_g[DATA_W-1:0]};
            end
            K_FHI: begin
                op_a = {i_x_q[DATA_W-1], i_x_q};
                op_b = {r_g[OUT_W-1], r_g[OUT_W-1:DATA_W]};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Accumulate step and the saturated results it produces.
    always_comb begin
        g_sum = (r_tag2.first ? GACC_W'(0) : r_gacc) + GACC_W'(r_prod);
        g_val = sat64(FACC_W'(g_sum >>> GRAD_SHIFT));
        if (r_tag2.kind == K_FHI) begin
            f_add = FACC_W'(r_prod) <<< DATA_W;
        end else begin
            f_add = FACC_W'(r_prod);
        end
        f_val = sat64(r_facc >>> FUNC_SHIFT);
    end

    // Pipeline tags and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1   <= '0;
            r_tag2   <= '0;
            r_fpend  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_tag1   <= i_tag;
            r_tag2   <= r_tag1;
            r_strobe <= 1'b0;
            if (r_fpend) begin
                r_fpend  <= 1'b0;
                r_strobe <= 1'b1;
            end else if (r_tag2.valid && r_tag2.kind == K_MAC && r_tag2.last) begin
                r_strobe <= 1'b1;
            end
            if (r_tag2.valid && r_tag2.kind == K_FHI && r_tag2.fin) begin
                r_fpend <= 1'b1;
            end
        end
    end

    // Multiplier stage.
    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
    end

    // Accumulators and result payload.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_facc <= '0;
        end else if (r_tag2.valid && (r_tag2.kind == K_FLO || r_tag2.kind == K_FHI)) begin
            r_facc <= r_facc + f_add;
        end
        if (r_tag2.valid && r_tag2.kind == K_MAC) begin
            r_gacc <= g_sum;
            if (r_tag2.last) begin
                r_g     <= g_val;
                r_kind  <= RK_GRAD;
                r_index <= r_tag2.row;
                r_value <= g_val;
                r_end   <= 1'b0;
            end
        end
        if (r_fpend) begin
            r_kind  <= RK_FUNC;
            r_index <= '0;
            r_value <= f_val;
            r_end   <= 1'b1;
        end
    end

    assign o_done         = r_fpend;
    assign o_strobe       = r_strobe;
    assign o_result_kind  = r_kind;
    assign o_result_index = r_index;
    assign o_result_value = r_value;
    assign o_run_end      = r_end;

endmodule

// ----- rtl/core/qfg_seq.sv -----
module qfg_seq
    import qfg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [DIM_W-1:0] i_n,
    input  logic             i_done,
    output logic             o_busy,
    output t_tag             o_tag,
    output logic [IDX_W-1:0] o_rd_row,
    output logic [IDX_W-1:0] o_rd_col,
    output logic [IDX_W-1:0] o_rd_xidx
);

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] n_row;
    logic [IDX_W-1:0] r_col;
    logic [IDX_W-1:0] n_col;
    logic [IDX_W-1:0] r_last_idx;

    // State register and the loop counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    // Highest index in use, taken when a run starts.
    always_ff @(posedge i_clk) begin
        if (i_go && r_state == ST_IDLE) begin
            r_last_idx <= IDX_W'(i_n - DIM_W'(1));
        end
    end

    // Walk each row through the multiplier, then fold its gradient into f.
    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        o_tag     = '0;
        o_rd_xidx = r_col;
        case (r_state)
            ST_IDLE: begin
                if (i_go) begin
                    n_state = ST_MAC;
                    n_row   = '0;
                    n_col   = '0;
                end
            end
            ST_MAC: begin
                o_tag.valid = 1'b1;
                o_tag.kind  = K_MAC;
                o_tag.first = (r_col == '0);
                o_tag.last  = (r_col == r_last_idx);
                o_tag.row   = r_row;
                if (r_col == r_last_idx) begin
                    n_state = ST_GAP;
                end else begin
                    n_col = r_col + IDX_W'(1);
                end
            end
            ST_GAP: begin
                // Lets the row's gradient settle before it is multiplied again.
                n_state = ST_FLO;
            end
            ST_FLO: begin
                o_tag.valid = 1'b1;
                o_tag.kind  = K_FLO;
                o_tag.row   = r_row;
                o_rd_xidx   = r_row;
                n_state     = ST_FHI;
            end
            ST_FHI: begin
                o_tag.valid = 1'b1;
                o_tag.kind  = K_FHI;
                o_tag.fin   = (r_row == r_last_idx);
                o_tag.row   = r_row;
                o_rd_xidx   = r_row;
                if (r_row == r_last_idx) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_state = ST_MAC;
                    n_row   = r_row + IDX_W'(1);
                    n_col   = '0;
                end
            end
            ST_DRAIN: begin
                if (i_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_rd_row = r_row;
    assign o_rd_col = r_col;

endmodule

// ----- rtl/core/quadratic_form_gradient.sv -----
// Channel   | Direction | Handshake                       | Payload
// ----------+-----------+---------------------------------+-------------------------------------
// config    | in        | i_cfg_we (write at clock edge)  | i_cfg_data (active_dimension)
// command   | in        | start high while busy is low    | i_operation, i_row_index,
//           |           |                                 | i_column_index, i_sample_value,
//           |           |                                 | i_final_element
// result    | out       | o_result_strobe, one cycle each | o_result_kind, o_result_index,
//           |           |                                 | o_result_value, o_run_end
//
// A matrix entry or a plain vector element is taken without raising busy. A final vector
// element keeps busy high while the one shared multiply-accumulate unit takes n matrix
// entries, a settling state and two partial products for f per row, then drains its
// pipeline; the f result is strobed in the cycle in which busy falls.
// Reset is synchronous and active low; it sets the dimension to 16, the stores keep no reset.
// The receiver cannot stall: each result is presented for exactly one cycle.
module quadratic_form_gradient
    import qfg_pkg::*;
#(
    parameter int MAX_DIMENSION = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [DIM_W-1:0]         i_cfg_data,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_operation,
    input  logic [IDX_W-1:0]         i_row_index,
    input  logic [IDX_W-1:0]         i_column_index,
    input  logic signed [DATA_W-1:0] i_sample_value,
    input  logic                     i_final_element,
    output logic                     o_result_strobe,
    output logic                     o_result_kind,
    output logic [IDX_W-1:0]         o_result_index,
    output logic signed [OUT_W-1:0]  o_result_value,
    output logic                     o_run_end
);

    localparam int CAP = (MAX_DIMENSION < 16) ? MAX_DIMENSION : 16;

    logic [DIM_W-1:0]  r_dim;
    logic [DIM_W-1:0]  eff_n;
    logic              accept;
    logic              go;
    logic              seq_busy;
    logic              mac_done;
    t_tag              issue_tag;
    logic [IDX_W-1:0]  rd_row;
    logic [IDX_W-1:0]  rd_col;
    logic [IDX_W-1:0]  rd_xidx;
    logic [DATA_W-1:0] p_q;
    logic [DATA_W-1:0] x_q;

    // Dimension register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_W'(16);
        end else if (i_cfg_we) begin
            r_dim <= i_cfg_data;
        end
    end

    // Clamp the dimension into the range the stores hold.
    always_comb begin
        if (r_dim == '0) begin
            eff_n = DIM_W'(1);
        end else if (r_dim > DIM_W'(CAP)) begin
            eff_n = DIM_W'(CAP);
        end else begin
            eff_n = r_dim;
        end
    end

    // Item acceptance; a final vector element starts a run.
    assign accept = start && !seq_busy;
    assign go     = accept && (i_operation == OP_VECTOR) && i_final_element;
    assign busy   = seq_busy;

    qfg_store #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_p    (accept && (i_operation == OP_MATRIX)),
        .i_wr_x    (accept && (i_operation == OP_VECTOR)),
        .i_wr_row  (i_row_index),
        .i_wr_col  (i_column_index),
        .i_wr_data (i_sample_value),
        .i_rd_row  (rd_row),
        .i_rd_col  (rd_col),
        .i_rd_xidx (rd_xidx),
        .o_p_q     (p_q),
        .o_x_q     (x_q)
    );

    qfg_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (go),
        .i_n       (eff_n),
        .i_done    (mac_done),
        .o_busy    (seq_busy),
        .o_tag     (issue_tag),
        .o_rd_row  (rd_row),
        .o_rd_col  (rd_col),
        .o_rd_xidx (rd_xidx)
    );

    qfg_mac u_mac (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (go),
        .i_tag          (issue_tag),
        .i_p_q          (p_q),
        .i_x_q          (x_q),
        .o_done         (mac_done),
        .o_strobe       (o_result_strobe),
        .o_result_kind  (o_result_kind),
        .o_result_index (o_result_index),
        .o_result_value (o_result_value),
        .o_run_end      (o_run_end)
    );

endmodule

// ----- tb/sv/quadratic_form_gradient_tb.sv -----
module quadratic_form_gradient_tb
    import qfg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 10;
    localparam int MAX_DIM       = 16;
    localparam int RANDOM_ITEMS  = 32;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PRINT_LIMIT   = 100;
    localparam int G_SHIFT       = 16;
    localparam int F_SHIFT       = 17;

    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_LSB = 32'h0000_0001;
    localparam logic [DATA_W-1:0] Q_NEG = 32'hFFFF_FFFF;

    // One result of an evaluation run as it appears on the result ports.
    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] index;
        logic [OUT_W-1:0] value;
        logic             run_end;
    } t_form_result;

    // One row of the directed stimulus table.
    typedef struct {
        bit                is_dim;
        logic              op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              fin;
        bit                typed;
        logic [OUT_W-1:0]  grad0;
        logic [OUT_W-1:0]  func;
    } t_stim_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [DIM_W-1:0]         i_cfg_data;
    logic                     start;
    logic                     busy;
    logic                     i_operation;
    logic [IDX_W-1:0]         i_row_index;
    logic [IDX_W-1:0]         i_column_index;
    logic signed [DATA_W-1:0] i_sample_value;
    logic                     i_final_element;
    logic                     o_result_strobe;
    logic                     o_result_kind;
    logic [IDX_W-1:0]         o_result_index;
    logic signed [OUT_W-1:0]  o_result_value;
    logic                     o_run_end;

    // Shadow copy of the block's state.
    logic signed [DATA_W-1:0] prec_mem [MAX_DIM][MAX_DIM];
    logic signed [DATA_W-1:0] vec_mem [MAX_DIM];
    logic [DIM_W-1:0]         dim_reg;

    t_form_result results_due[$];
    t_form_result due;
    t_stim_row    directed_rows[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           items_sent = 0;
    bit           gapless = 1'b0;

    quadratic_form_gradient #(
        .MAX_DIMENSION(MAX_DIM)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .i_sample_value (i_sample_value),
        .i_final_element(i_final_element),
        .o_result_strobe(o_result_strobe),
        .o_result_kind  (o_result_kind),
        .o_result_index (o_result_index),
        .o_result_value (o_result_value),
        .o_run_end      (o_run_end)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Free-running cycle count; the run is cut off at the limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    function automatic t_form_result make_result(input logic kind, input logic [IDX_W-1:0] index,
                                                 input logic [OUT_W-1:0] value,
                                                 input logic run_end);
        t_form_result r;
        r.kind    = kind;
        r.index   = index;
        r.value   = value;
        r.run_end = run_end;
        return r;
    endfunction

    // Number of rows taking part in a run, after clamping the register.
    function automatic int active_rows();
        if (dim_reg == 0) begin
            return 1;
        end
        if (dim_reg > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(dim_reg);
    endfunction

    // Clamp a wide signed value into the signed 64-bit range.
    function automatic logic [OUT_W-1:0] clamp64(input logic signed [127:0] v);
        if ((&v[127:OUT_W-1]) || !(|v[127:OUT_W-1])) begin
            return v[OUT_W-1:0];
        end
        return v[127] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    endfunction

    function automatic void store_entry(input logic op, input logic [IDX_W-1:0] row,
                                        input logic [IDX_W-1:0] col,
                                        input logic [DATA_W-1:0] value);
        if (op == OP_MATRIX) begin
            prec_mem[row][col] = value;
        end else begin
            vec_mem[row] = value;
        end
    endfunction

    // Gradient g = P*x, then f = x.g / 2, both floored at the Q16.16 point.
    function automatic void evaluate_form();
        logic signed [71:0]      gacc;
        logic signed [127:0]     facc;
        logic signed [OUT_W-1:0] g;
        int                      n;
        n    = active_rows();
        facc = '0;
        for (int i = 0; i < n; i++) begin
            gacc = '0;
            for (int j = 0; j < n; j++) begin
                gacc += prec_mem[i][j] * vec_mem[j];
            end
            g = clamp64(gacc >>> G_SHIFT);
            facc += vec_mem[i] * g;
            results_due.push_back(make_result(RK_GRAD, IDX_W'(i), g, 1'b0));
        end
        results_due.push_back(make_result(RK_FUNC, '0, clamp64(facc >>> F_SHIFT), 1'b1));
    endfunction

    function automatic void apply_item(input logic op, input logic [IDX_W-1:0] row,
                                       input logic [IDX_W-1:0] col,
                                       input logic [DATA_W-1:0] value, input logic fin);
        store_entry(op, row, col, value);
        if (op == OP_VECTOR && fin) begin
            evaluate_form();
        end
    endfunction

    function automatic logic [DATA_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return '0;
            3: return Q_NEG;
            4, 5: return DATA_W'($urandom_range(0, 'h7FFFF)) - 32'h0004_0000;
            default: return $urandom();
        endcase
    endfunction

    // Mostly back to back, some short gaps and a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gapless || r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_stim_row cmd_row(input logic op, input logic [IDX_W-1:0] row,
                                          input logic [IDX_W-1:0] col,
                                          input logic [DATA_W-1:0] value, input logic fin);
        t_stim_row s;
        s.is_dim = 1'b0;
        s.op     = op;
        s.row    = row;
        s.col    = col;
        s.value  = value;
        s.fin    = fin;
        s.typed  = 1'b0;
        s.grad0  = '0;
        s.func   = '0;
        return s;
    endfunction

    // Final element 0 of a one-row run whose results are known outright.
    function automatic t_stim_row checked_row(input logic [DATA_W-1:0] value,
                                              input logic [OUT_W-1:0] grad0,
                                              input logic [OUT_W-1:0] func);
        t_stim_row s;
        s       = cmd_row(OP_VECTOR, '0, '0, value, 1'b1);
        s.typed = 1'b1;
        s.grad0 = grad0;
        s.func  = func;
        return s;
    endfunction

    function automatic t_stim_row dim_row(input logic [DIM_W-1:0] d);
        t_stim_row s;
        s        = cmd_row(OP_MATRIX, '0, '0, DATA_W'(d), 1'b0);
        s.is_dim = 1'b1;
        return s;
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic send_item(input logic op, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value,
                             input logic fin);
        @(negedge i_clk);
        start           <= 1'b1;
        i_operation     <= op;
        i_row_index     <= row;
        i_column_index  <= col;
        i_sample_value  <= value;
        i_final_element <= fin;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    task automatic issue(input logic op, input logic [IDX_W-1:0] row,
                         input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value,
                         input logic fin);
        send_item(op, row, col, value, fin);
        apply_item(op, row, col, value, fin);
    endtask

    task automatic idle(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Stop sending, let every pending result arrive and the block fall idle.
    task automatic wait_quiet();
        @(negedge i_clk);
        start <= 1'b0;
        while (results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_dimension(input logic [DIM_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        dim_reg = d;
    endtask

    // Each strobed result is compared with the oldest one still owed.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_strobe === 1'b1) begin
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0b index %0d value %h",
                                          o_result_kind, o_result_index, o_result_value));
            end else begin
                due = results_due.pop_front();
                if (o_result_kind !== due.kind) begin
                    report_mismatch($sformatf("kind %0b, want %0b", o_result_kind, due.kind));
                end
                if (o_result_index !== due.index) begin
                    report_mismatch($sformatf("index %0d, want %0d",
                                              o_result_index, due.index));
                end
                if (o_result_value !== due.value) begin
                    report_mismatch($sformatf("value %h, want %h (kind %0b index %0d)",
                                              o_result_value, due.value, due.kind, due.index));
                end
                if (o_run_end !== due.run_end) begin
                    report_mismatch($sformatf("run_end %0b, want %0b",
                                              o_run_end, due.run_end));
                end
            end
        end
    end

    initial begin
        t_stim_row stim;
        int        n;
        int        nw;
        int        runs;
        int        random_base;
        int        pick;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        start           = 1'b0;
        i_operation     = OP_MATRIX;
        i_row_index     = '0;
        i_column_index  = '0;
        i_sample_value  = '0;
        i_final_element = 1'b0;
        dim_reg         = DIM_W'(MAX_DIM);

        // Directed table. Results typed in here apply to one-row runs only.
        directed_rows.push_back(cmd_row(OP_VECTOR, '0, '0, Q_MIN, 1'b1));
        directed_rows.push_back(dim_row(DIM_W'(1)));
        directed_rows.push_back(cmd_row(OP_MATRIX, '0, '0, Q_ONE, 1'b1));
        directed_rows.push_back(checked_row(Q_MIN, 64'hFFFF_FFFF_8000_0000,
                                            64'h0000_2000_0000_0000));
        directed_rows.push_back(checked_row(Q_MAX, 64'h0000_0000_7FFF_FFFF,
                                            64'h0000_1FFF_FFFF_8000));
        directed_rows.push_back(cmd_row(OP_VECTOR, IDX_W'(5), IDX_W'(9), 32'h1234_5678, 1'b0));
        directed_rows.push_back(checked_row('0, '0, '0));
        directed_rows.push_back(checked_row(Q_NEG, 64'hFFFF_FFFF_FFFF_FFFF, '0));
        directed_rows.push_back(cmd_row(OP_MATRIX, '0, '0, Q_NEG, 1'b0));
        directed_rows.push_back(checked_row(Q_LSB, 64'hFFFF_FFFF_FFFF_FFFF,
                                            64'hFFFF_FFFF_FFFF_FFFF));
        directed_rows.push_back(dim_row(DIM_W'(0)));
        directed_rows.push_back(checked_row(32'h0002_0000, 64'hFFFF_FFFF_FFFF_FFFE,
                                            64'hFFFF_FFFF_FFFF_FFFE));
        directed_rows.push_back(dim_row(DIM_W'(4)));
        for (int i = 0; i < 4; i++) begin
            directed_rows.push_back(cmd_row(OP_MATRIX, IDX_W'(i), IDX_W'(i), Q_MAX, 1'b0));
        end
        // Alternating extremes against a strong diagonal push f close to the positive limit.
        for (int i = 0; i < 4; i++) begin
            directed_rows.push_back(cmd_row(OP_VECTOR, IDX_W'(i), IDX_W'(15 - i),
                                            (i % 2) ? Q_MIN : Q_MAX, i == 3));
        end
        directed_rows.push_back(dim_row(DIM_W'(31)));
        directed_rows.push_back(cmd_row(OP_MATRIX, IDX_W'(15), IDX_W'(15), 32'h5555_5555,
                                        1'b0));
        directed_rows.push_back(cmd_row(OP_VECTOR, IDX_W'(15), IDX_W'(3), 32'hAAAA_AAAA, 1'b1));
        directed_rows.push_back(dim_row(DIM_W'(17)));
        directed_rows.push_back(cmd_row(OP_VECTOR, IDX_W'(10), '0, Q_MAX, 1'b1));

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Load every store entry first so that no run ever reads an unwritten one.
        for (int r = 0; r < MAX_DIM; r++) begin
            for (int c = 0; c < MAX_DIM; c++) begin
                issue(OP_MATRIX, IDX_W'(r), IDX_W'(c), Q_MIN, 1'b0);
                idle(pick_gap());
            end
        end
        for (int j = 0; j < MAX_DIM; j++) begin
            issue(OP_VECTOR, IDX_W'(j), IDX_W'(j), Q_MIN, 1'b0);
            idle(pick_gap());
        end

        // Directed part: the first run uses the reset dimension.
        foreach (directed_rows[k]) begin
            stim = directed_rows[k];
            if (stim.is_dim) begin
                wait_quiet();
                write_dimension(stim.value[DIM_W-1:0]);
            end else begin
                send_item(stim.op, stim.row, stim.col, stim.value, stim.fin);
                if (stim.typed) begin
                    store_entry(stim.op, stim.row, stim.col, stim.value);
                    results_due.push_back(make_result(RK_GRAD, '0, stim.grad0, 1'b0));
                    results_due.push_back(make_result(RK_FUNC, '0, stim.func, 1'b1));
                end else begin
                    apply_item(stim.op, stim.row, stim.col, stim.value, stim.fin);
                end
                idle(pick_gap());
            end
        end

        // Random part: phases at one dimension each, mostly complete load-and-run sequences.
        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS) begin
            wait_quiet();
            case ($urandom_range(0, 9))
                0: write_dimension(DIM_W'(0));
                1: write_dimension(DIM_W'(MAX_DIM));
                2: write_dimension(DIM_W'($urandom_range(17, 31)));
                3: write_dimension(DIM_W'(1));
                default: write_dimension(DIM_W'($urandom_range(1, 6)));
            endcase
            gapless = ($urandom_range(0, 3) == 0);
            n       = active_rows();
            runs    = $urandom_range(1, 4);
            for (int s = 0; s < runs && items_sent - random_base < RANDOM_ITEMS; s++) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    // Well-formed: matrix updates inside the active block, then a full vector.
                    nw = $urandom_range(0, (n <= 6) ? n * n : 2 * n);
                    for (int k = 0; k < nw; k++) begin
                        issue(OP_MATRIX, IDX_W'($urandom_range(0, n - 1)),
                              IDX_W'($urandom_range(0, n - 1)),
                              pick_sample(), $urandom_range(0, 3) == 0);
                        idle(pick_gap());
                    end
                    for (int j = 0; j < n; j++) begin
                        issue(OP_VECTOR, IDX_W'(j), IDX_W'($urandom_range(0, 15)),
                              pick_sample(), j == n - 1);
                        idle(pick_gap());
                    end
                end else if (pick < 9) begin
                    // Noise and broken sequences: any index, any flag.
                    nw = $urandom_range(1, 6);
                    for (int k = 0; k < nw; k++) begin
                        issue(1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 15)),
                              IDX_W'($urandom_range(0, 15)), pick_sample(),
                              $urandom_range(0, 2) == 0);
                        idle(pick_gap());
                    end
                end else begin
                    wait_quiet();
                end
            end
        end

        wait_quiet();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
